// ===== rtl/lglw_pkg.sv =====
`default_nettype none

package lglw_pkg;

    localparam int NODE_COUNT  = 128;
    localparam int MAX_DEGREE  = 6;
    localparam int NODE_AW     = $clog2(NODE_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0]        LN2_Q32 = 32'd2977044472;
    localparam logic signed [31:0] ONE_Q27 = 32'sd134217728;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [2:0] CFG_GRID_MODE = 3'd0;
    localparam logic [2:0] CFG_DEGREE    = 3'd1;
    localparam logic [2:0] CFG_INTERVALS = 3'd2;
    localparam logic [2:0] CFG_LOG_XMIN  = 3'd3;
    localparam logic [2:0] CFG_LOG_STEP  = 3'd4;
    localparam logic [2:0] CFG_INV_STEP  = 3'd5;

    typedef struct packed {
        logic               grid_mode;
        logic [2:0]         degree;
        logic [6:0]         intervals;
        logic signed [31:0] log_xmin;
        logic [30:0]        log_step;
        logic [31:0]        inv_log_step;
    } cfg_t;

    typedef struct packed {
        logic               is_query;
        logic [6:0]         idx;
        logic [31:0]        x;
        logic signed [31:0] log_node;
    } job_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ,
        ST_LNMUL,
        ST_LNFIN,
        ST_EXTA,
        ST_EXTB,
        ST_EXTC,
        ST_FETCH,
        ST_FWAIT,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_SEARCH,
        ST_TOP,
        ST_FMUL,
        ST_FACT_R,
        ST_FACT,
        ST_NK,
        ST_DIVCHK,
        ST_DIV,
        ST_FSAT,
        ST_WMUL,
        ST_WACC,
        ST_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = SAT_MAX;
        else if (v < -64'sd2147483648)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lglw_item_if.sv =====
`default_nettype none

interface lglw_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [6:0]         node_index;
    logic [31:0]        x_value;
    logic signed [31:0] log_node;

    modport source (output valid, output kind, output node_index, output x_value,
                    output log_node, input ready);
    modport sink (input valid, input kind, input node_index, input x_value,
                  input log_node, output ready);
endinterface

`default_nettype wire

// ===== rtl/lglw_result_if.sv =====
`default_nettype none

interface lglw_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] weight;
    logic               in_support;

    modport source (output valid, output weight, output in_support, input ready);
    modport sink (input valid, input weight, input in_support, output ready);
endinterface

`default_nettype wire

// ===== rtl/lglw_ram.sv =====
`default_nettype none

module lglw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/lglw_front.sv =====
`default_nettype none

module lglw_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lglw_item_if.sink          item,
    input  wire logic          pop,
    output logic               job_valid,
    output lglw_pkg::job_t     job
);
    import lglw_pkg::*;

    job_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                push;
    job_t                word;

    assign item.ready = (count_reg < QUEUE_CW'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign job_valid  = (count_reg != '0);
    assign job        = slot_reg[rd_ptr_reg];

    // classify the incoming word
    always_comb
    begin
        word.is_query = (item.kind == KIND_QUERY);
        word.idx      = item.node_index;
        word.x        = item.x_value;
        word.log_node = item.log_node;
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && job_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(pop && job_valid))
            count_next = count_reg + 1'b1;
        else if (!push && pop && job_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lglw_back.sv =====
`default_nettype none

module lglw_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lglw_pkg::cfg_t cfg,
    input  wire logic          job_valid,
    input  wire lglw_pkg::job_t job,
    output logic               pop,
    lglw_result_if.source      result
);
    import lglw_pkg::*;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [6:0]         beta_reg, beta_next;
    logic [31:0]        xn_reg, xn_next;
    logic [4:0]         p_reg, p_next;
    logic [31:0]        y_reg, y_next;
    logic [29:0]        frac_reg, frac_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [47:0] lx_reg, lx_next;
    logic signed [31:0] ext_a_reg, ext_a_next;
    logic signed [47:0] ext_reg, ext_next;
    logic signed [9:0]  fidx_reg, fidx_next;
    logic signed [47:0] node_reg, node_next;
    logic signed [47:0] lo_reg, lo_next;
    logic signed [47:0] hi_reg, hi_next;
    logic signed [47:0] top_reg, top_next;
    logic [2:0]         j_reg, j_next;
    logic [2:0]         delta_reg, delta_next;
    logic signed [47:0] fact_reg, fact_next;
    logic [59:0]        dvd_reg, dvd_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic signed [31:0] f_reg, f_next;
    logic signed [31:0] w_reg, w_next;
    logic               sup_reg, sup_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] weight_reg, weight_next;
    logic               in_sup_reg, in_sup_next;

    logic               ram_we;
    logic [NODE_AW-1:0] ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [NODE_AW-1:0] ram_raddr;
    logic [31:0]        ram_rdata;

    logic [6:0]         nx;
    logic [2:0]         deg;
    logic [6:0]         bound;
    logic [2:0]         span;
    logic [7:0]         fidx_c;

    lglw_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nx     = (cfg.intervals < 7'd2) ? 7'd2 : cfg.intervals;
    assign deg    = (cfg.degree > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : cfg.degree;
    assign bound  = ({4'd0, deg} > beta_reg) ? 7'd0 : beta_reg - {4'd0, deg};
    assign span   = 3'(beta_reg - bound);
    assign fidx_c = fidx_reg[9] ? 8'd0 : fidx_reg[7:0];

    assign result.valid      = out_valid_reg;
    assign result.weight     = weight_reg;
    assign result.in_support = in_sup_reg;

    always_comb
    begin
        logic [4:0]          sh;
        logic [31:0]         xs;
        logic [63:0]         sq;
        logic [32:0]         t;
        logic signed [6:0]   pm;
        logic signed [47:0]  lnsum;
        logic signed [9:0]   ma;
        logic signed [33:0]  mb;
        logic signed [47:0]  base;
        logic signed [43:0]  mprod;
        logic signed [31:0]  diff;
        logic signed [64:0]  fprod;
        logic signed [3:0]   d;
        logic signed [47:0]  dnum;
        logic signed [31:0]  num;
        logic signed [31:0]  den;
        logic [31:0]         anum;
        logic [32:0]         r2;
        logic                ge;
        logic signed [47:0]  rnd;

        state_next     = state_reg;
        ret_next       = ret_reg;
        beta_next      = beta_reg;
        xn_next        = xn_reg;
        p_next         = p_reg;
        y_next         = y_reg;
        frac_next      = frac_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        lx_next        = lx_reg;
        ext_a_next     = ext_a_reg;
        ext_next       = ext_reg;
        fidx_next      = fidx_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        top_next       = top_reg;
        j_next         = j_reg;
        delta_next     = delta_reg;
        fact_next      = fact_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        f_next         = f_reg;
        w_next         = w_reg;
        sup_next       = sup_reg;
        out_valid_next = out_valid_reg;
        weight_next    = weight_reg;
        in_sup_next    = in_sup_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = job.idx[NODE_AW-1:0];
        ram_wdata      = job.log_node;
        ram_re         = 1'b0;
        ram_raddr      = fidx_c[NODE_AW-1:0];

        sh    = 5'd16 >> cnt_reg[2:0];
        xs    = xn_reg << sh;
        sq    = y_reg * y_reg;
        t     = sq[63:31];
        pm    = $signed({2'b00, p_reg}) - 7'sd31;
        lnsum = 48'(pm) * 48'($signed({1'b0, LN2_Q32}))
              + $signed({16'd0, prod_reg[61:30]});
        ma    = $signed({2'b00, fidx_c});
        mb    = $signed({3'b000, cfg.log_step});
        base  = 48'(cfg.log_xmin);
        if (cfg.grid_mode)
        begin
            ma   = $signed({2'b00, fidx_c}) - $signed({3'b000, nx});
            mb   = ext_reg[33:0];
            base = '0;
        end
        mprod = ma * mb;
        diff  = sat32(64'(lx_reg - top_reg));
        fprod = diff * $signed({1'b0, cfg.inv_log_step});
        d     = $signed({1'b0, j_reg}) - $signed({1'b0, delta_reg});
        dnum  = fact_reg + 48'(d * ONE_Q27);
        num   = sat32(64'(lx_reg - node_reg));
        den   = sat32(64'(top_reg - node_reg));
        anum  = num[31] ? 32'(-num) : num;
        r2    = {rem_reg, quo_reg[31]};
        ge    = (r2 >= {1'b0, dvs_reg});
        rnd   = 48'((prod_reg + 64'sd67108864) >>> 27);

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    if (!job.is_query)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        beta_next = job.idx;
                        w_next    = '0;
                        sup_next  = 1'b0;
                        xn_next   = job.x;
                        p_next    = 5'd31;
                        cnt_next  = '0;
                        state_next = (job.x == '0) ? ST_EMIT : ST_NORM;
                    end
                end
            end
            // binary normalization: 16, 8, 4, 2, 1
            ST_NORM:
            begin
                if ((xn_reg >> (6'd32 - {1'b0, sh})) == '0)
                begin
                    xn_next = xs;
                    p_next  = p_reg - sh;
                end
                if (cnt_reg == 6'd4)
                begin
                    y_next     = ((xn_reg >> (6'd32 - {1'b0, sh})) == '0) ? xs : xn_reg;
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQ:
            begin
                if (t[32])
                begin
                    y_next    = t[32:1];
                    frac_next = {frac_reg[28:0], 1'b1};
                end
                else
                begin
                    y_next    = t[31:0];
                    frac_next = {frac_reg[28:0], 1'b0};
                end
                if (cnt_reg == 6'd29)
                    state_next = ST_LNMUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_LNMUL:
            begin
                prod_next  = $signed({2'b00, {32'd0, frac_reg} * {30'd0, LN2_Q32}});
                state_next = ST_LNFIN;
            end
            ST_LNFIN:
            begin
                lx_next    = (lnsum + 48'sd32) >>> 6;
                state_next = ST_EXTA;
            end
            // extension width from the last table bin
            ST_EXTA:
            begin
                ram_re     = 1'b1;
                ram_raddr  = NODE_AW'(nx - 7'd1);
                state_next = ST_EXTB;
            end
            ST_EXTB:
            begin
                ext_a_next = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = NODE_AW'(nx - 7'd2);
                state_next = ST_EXTC;
            end
            ST_EXTC:
            begin
                ext_next   = 48'(ext_a_reg) - 48'($signed(ram_rdata));
                fidx_next  = $signed({3'b000, bound});
                ret_next   = ST_CHK_LO;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                if (fidx_c == {1'b0, nx})
                    node_next = '0;
                else if (cfg.grid_mode && (fidx_c < {1'b0, nx}))
                    node_next = 48'($signed(ram_rdata));
                else
                    node_next = base + 48'(mprod);
                state_next = ret_reg;
            end
            ST_CHK_LO:
            begin
                lo_next    = node_reg;
                fidx_next  = $signed({3'b000, beta_reg}) + 10'sd1;
                ret_next   = ST_CHK_HI;
                state_next = ST_FETCH;
            end
            ST_CHK_HI:
            begin
                hi_next = node_reg;
                if ((lx_reg < lo_reg) || (lx_reg >= node_reg))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    j_next     = '0;
                    fidx_next  = $signed({3'b000, beta_reg});
                    ret_next   = ST_SEARCH;
                    state_next = ST_FETCH;
                end
            end
            ST_SEARCH:
            begin
                ret_next   = ST_SEARCH;
                state_next = ST_FETCH;
                if ((lx_reg >= node_reg) && (lx_reg < hi_reg))
                begin
                    fidx_next = $signed({3'b000, beta_reg});
                    ret_next  = ST_TOP;
                end
                else
                begin
                    hi_next = node_reg;
                    j_next  = j_reg + 1'b1;
                    if (j_reg == span)
                    begin
                        fidx_next = $signed({3'b000, beta_reg});
                        ret_next  = ST_TOP;
                    end
                    else
                    begin
                        fidx_next = $signed({3'b000, beta_reg})
                                  - $signed({7'd0, j_reg}) - 10'sd1;
                    end
                end
            end
            ST_TOP:
            begin
                top_next   = node_reg;
                w_next     = ONE_Q27;
                delta_next = '0;
                state_next = cfg.grid_mode ? ST_FACT : ST_FMUL;
            end
            ST_FMUL:
            begin
                prod_next  = fprod[63:0];
                state_next = ST_FACT_R;
            end
            ST_FACT_R:
            begin
                fact_next  = 48'((prod_reg + 64'sd4194304) >>> 23);
                state_next = ST_FACT;
            end
            ST_FACT:
            begin
                if (delta_reg > deg)
                begin
                    sup_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (delta_reg == j_reg)
                begin
                    delta_next = delta_reg + 1'b1;
                end
                else if (cfg.grid_mode)
                begin
                    fidx_next  = $signed({3'b000, beta_reg}) - $signed({7'd0, j_reg})
                               + $signed({7'd0, delta_reg});
                    ret_next   = ST_NK;
                    state_next = ST_FETCH;
                end
                else
                begin
                    dvd_next   = 60'(dnum[47] ? -dnum : dnum);
                    dvs_next   = 32'(d[3] ? -d : d);
                    neg_next   = dnum[47] ^ d[3];
                    state_next = ST_DIVCHK;
                end
            end
            ST_NK:
            begin
                if (den == '0)
                begin
                    f_next     = (num > 0) ? SAT_MAX : ((num < 0) ? SAT_MIN : '0);
                    state_next = ST_WMUL;
                end
                else
                begin
                    dvd_next   = {1'b0, anum, 27'd0};
                    dvs_next   = den[31] ? 32'(-den) : den;
                    neg_next   = num[31] ^ den[31];
                    state_next = ST_DIVCHK;
                end
            end
            // quotient above 32 bits saturates outright
            ST_DIVCHK:
            begin
                ovf_next = ({4'd0, dvd_reg[59:32]} >= dvs_reg);
                rem_next = {4'd0, dvd_reg[59:32]};
                quo_next = dvd_reg[31:0];
                cnt_next = '0;
                state_next = ({4'd0, dvd_reg[59:32]} >= dvs_reg) ? ST_FSAT : ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? 32'(r2 - {1'b0, dvs_reg}) : r2[31:0];
                quo_next = {quo_reg[30:0], ge};
                if (cnt_reg == 6'd31)
                    state_next = ST_FSAT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FSAT:
            begin
                if (ovf_reg)
                    f_next = neg_reg ? SAT_MIN : SAT_MAX;
                else if (neg_reg)
                    f_next = (quo_reg > 32'h8000_0000) ? SAT_MIN : 32'(-quo_reg);
                else
                    f_next = (quo_reg > 32'h7FFF_FFFF) ? SAT_MAX : quo_reg;
                state_next = ST_WMUL;
            end
            ST_WMUL:
            begin
                prod_next  = w_reg * f_reg;
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                w_next     = sat32(64'(rnd));
                delta_next = delta_reg + 1'b1;
                state_next = ST_FACT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    weight_next    = w_reg;
                    in_sup_next    = sup_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beta_reg   <= beta_next;
        xn_reg     <= xn_next;
        p_reg      <= p_next;
        y_reg      <= y_next;
        frac_reg   <= frac_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        lx_reg     <= lx_next;
        ext_a_reg  <= ext_a_next;
        ext_reg    <= ext_next;
        fidx_reg   <= fidx_next;
        node_reg   <= node_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        top_reg    <= top_next;
        j_reg      <= j_next;
        delta_reg  <= delta_next;
        fact_reg   <= fact_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        f_reg      <= f_next;
        w_reg      <= w_next;
        sup_reg    <= sup_next;
        weight_reg <= weight_next;
        in_sup_reg <= in_sup_next;
    end

endmodule

`default_nettype wire

// ===== rtl/log_grid_lagrange_weight.sv =====
`default_nettype none

// Lagrange interpolation weight of grid node node_index at point x_value, worked
// out on ln x over a uniform log grid (grid_mode 0) or a table of ln node values
// written by load words (grid_mode 1). Words enter a two-entry queue and are
// carried out in order; a load is written into the table RAM and gives no result,
// a query gives exactly one result word. The run time of a query is set by the
// 30 squaring steps of the log unit, the registered table RAM read of each node
// fetched, and the one-bit-a-cycle 32-step divider that forms each degree factor.
// Zero x and points outside the support finish early.
module log_grid_lagrange_weight (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lglw_item_if.sink        item,
    lglw_result_if.source    result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import lglw_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic job_valid;
    job_t job;
    logic pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_MODE: cfg_next.grid_mode    = cfg_data[0];
                CFG_DEGREE:    cfg_next.degree       = cfg_data[2:0];
                CFG_INTERVALS: cfg_next.intervals    = cfg_data[6:0];
                CFG_LOG_XMIN:  cfg_next.log_xmin     = cfg_data;
                CFG_LOG_STEP:  cfg_next.log_step     = cfg_data[30:0];
                CFG_INV_STEP:  cfg_next.inv_log_step = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_mode    <= 1'b0;
            cfg_reg.degree       <= 3'd3;
            cfg_reg.intervals    <= 7'd50;
            cfg_reg.log_xmin     <= -32'sd772614000;
            cfg_reg.log_step     <= 31'd15452280;
            cfg_reg.inv_log_step <= 32'd72861000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lglw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .pop       (pop),
        .job_valid (job_valid),
        .job       (job)
    );

    lglw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
